/* rtl/rsm_pkg.sv */
// package for the row softmax block: widths, exp table
package rsm_pkg;
    localparam int SCORE_W = 16;
    localparam int PROB_W  = 16;
    localparam int COL_W   = 6;
    localparam int RHO_W   = 16;
    localparam int LEN_W   = 7;
    localparam int MAX_COLUMNS_DEF = 64;

    localparam logic REG_RHO = 1'b0;
    localparam logic REG_LEN = 1'b1;

    function automatic logic [31:0] exp_tab(input logic [3:0] b);
        logic [31:0] v;
        unique case (b)
            4'd0: v = 32'd4278222805;
            4'd1: v = 32'd4261543595;
            4'd2: v = 32'd4228380000;
            4'd3: v = 32'd4162825044;
            4'd4: v = 32'd4034748382;
            4'd5: v = 32'd3790295335;
            4'd6: v = 32'd3344923893;
            4'd7: v = 32'd2605029347;
            4'd8: v = 32'd1580030169;
            4'd9: v = 32'd581260615;
            4'd10: v = 32'd78665070;
            4'd11: v = 32'd1440801;
            default: v = 32'd0;
        endcase
        return v;
    endfunction
endpackage

/* rtl/rsm_exp.sv */
// iterative exp(-t) unit, one table factor per cycle, q1.32 result
module rsm_exp
    import rsm_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [15:0] i_t,
    output logic        o_done,
    output logic [32:0] o_acc
);
    logic [32:0] r_acc;
    logic [15:0] r_t;
    logic [3:0]  r_bit;
    logic        r_busy;
    logic        r_done;
    logic [64:0] w_prod;

    assign w_prod = r_acc * exp_tab(r_bit) + 65'h80000000;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_acc  <= (i_t >= 16'd4096) ? 33'd0 : 33'h1_0000_0000;
                r_t    <= i_t;
                r_bit  <= 4'd0;
                r_busy <= (i_t < 16'd4096);
                r_done <= (i_t >= 16'd4096);
            end else if (r_busy) begin
                if (r_t[r_bit]) r_acc <= w_prod[64:32];
                if (r_bit == 4'd11) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
                r_bit <= r_bit + 4'd1;
            end
        end
    end

    assign o_done = r_done;
    assign o_acc  = r_acc;
endmodule

/* rtl/rsm_div.sv */
// restoring divider, one quotient bit per cycle
module rsm_div
    import rsm_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [48:0] i_num,
    input  logic [32:0] i_den,
    output logic        o_done,
    output logic [48:0] o_quo
);
    logic [48:0] r_quo;
    logic [33:0] r_rem;
    logic [32:0] r_den;
    logic [5:0]  r_cnt;
    logic        r_busy;
    logic        r_done;
    logic [33:0] w_sh;

    assign w_sh = {r_rem[32:0], r_quo[48]};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_quo  <= i_num;
                r_rem  <= '0;
                r_den  <= i_den;
                r_cnt  <= 6'd0;
                r_busy <= 1'b1;
            end else if (r_busy) begin
                if (w_sh >= {1'b0, r_den}) begin
                    r_rem <= w_sh - {1'b0, r_den};
                    r_quo <= {r_quo[47:0], 1'b1};
                end else begin
                    r_rem <= w_sh;
                    r_quo <= {r_quo[47:0], 1'b0};
                end
                if (r_cnt == 6'd48) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
                r_cnt <= r_cnt + 6'd1;
            end
        end
    end

    assign o_done = r_done;
    assign o_quo  = r_quo;
endmodule

/* rtl/row_softmax_with_null_term_top.sv */
// top level of the row softmax with null term block
// Scores are taken one per start beat while busy is low; a score that does not end the row
// passes through the load state back to idle. The row-ending score starts a pass over the
// row memory, a column at a time through the iterative exp unit (which skips its table steps
// when the score is 16 or more below the maximum), then exp(-m), plus the 49-step divider
// when m is negative and exp(m) has not underflowed. Each column then goes through a memory
// read, the exp unit again, the 49-step normalizing divide and an output state (the divide
// is skipped when the denominator is zero). Each probability beat is on the outputs for
// one cycle with o_valid high; the receiver cannot stall it, and busy drops in the cycle
// the last beat of the row is on the outputs.
module row_softmax_with_null_term_top
    import rsm_pkg::*;
#(
    parameter int MAX_COLUMNS = MAX_COLUMNS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  logic signed [15:0] i_score,
    input  logic               i_cfg_we,
    input  logic               i_cfg_index,
    input  logic [15:0]        i_cfg_data,
    output logic               o_valid,
    output logic [15:0]        o_probability,
    output logic [5:0]         o_column,
    output logic               o_row_done
);
    localparam int AW = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1;
    localparam int CW = $clog2(MAX_COLUMNS + 1);
    localparam int SUM_W = 16 + CW;

    typedef enum logic [9:0] {
        S_IDLE  = 10'b0000000001,
        S_LOAD  = 10'b0000000010,
        S_ERD   = 10'b0000000100,
        S_EXP   = 10'b0000001000,
        S_EM    = 10'b0000010000,
        S_EMDIV = 10'b0000100000,
        S_PRD   = 10'b0001000000,
        S_PEXP  = 10'b0010000000,
        S_PDIV  = 10'b0100000000,
        S_OUT   = 10'b1000000000
    } t_state;

    t_state r_state;
    logic [15:0] r_mem [MAX_COLUMNS];
    logic [15:0] r_rdata;
    logic [15:0] r_rho;
    logic [LEN_W-1:0] r_len;
    logic signed [15:0] r_max;
    logic signed [15:0] r_score;
    logic [CW-1:0] r_fill;
    logic [CW-1:0] r_idx;
    logic [SUM_W-1:0] r_sum;
    logic [32:0] r_den;
    logic [32:0] r_em;
    logic [31:0] r_ssum;
    logic [16:0] r_e;
    logic [15:0] r_prob;
    logic [5:0]  r_col;
    logic        r_valid;
    logic        r_last;
    logic        r_dgo;
    logic        r_xgo;

    logic [CW-1:0] w_len;
    logic [CW-1:0] w_fill_eff;
    logic [CW:0]   w_fill_nxt;
    logic          x_start;
    logic [15:0]   x_t;
    logic          x_done;
    logic [32:0]   x_acc;
    logic          d_start;
    logic [48:0]   d_num;
    logic [32:0]   d_den;
    logic          d_done;
    logic [48:0]   d_quo;
    logic [16:0]   w_e;
    logic [48:0]   w_rs;
    logic [32:0]   w_sat;

    always_comb begin
        if (r_len == '0) w_len = CW'(1);
        else if (32'(r_len) > MAX_COLUMNS) w_len = CW'(MAX_COLUMNS);
        else w_len = CW'(r_len);
        w_fill_eff = (32'(r_fill) >= MAX_COLUMNS) ? CW'(MAX_COLUMNS - 1) : r_fill;
        w_fill_nxt = {1'b0, w_fill_eff} + 1'b1;
    end

    assign w_e = 17'((34'(x_acc) + 34'h8000) >> 16);
    assign w_rs = 49'(r_rho) * 49'(r_sum) + 49'h8000;
    assign w_sat = (d_quo > 49'hFFFFFFFF) ? 33'hFFFFFFFF : d_quo[32:0];

    always_comb begin
        x_start = 1'b0;
        x_t     = 16'(r_max - $signed(r_rdata));
        d_num   = 49'h1_0000_0000_0000 + 49'(x_acc >> 1);
        d_den   = x_acc;
        if (r_state == S_EM) begin
            x_t = r_max[15] ? 16'(-r_max) : r_max;
        end
        if (r_state == S_PDIV) begin
            d_num = 49'(r_rho) * 49'(r_e) + 49'(r_den >> 1);
            d_den = r_den;
        end
        unique case (r_state)
            S_EXP, S_PEXP: x_start = r_xgo;
            S_EM: x_start = (r_idx == '0);
            default: ;
        endcase
    end

    assign d_start = r_dgo;

    rsm_exp u_exp (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(x_start), .i_t(x_t),
        .o_done(x_done), .o_acc(x_acc)
    );

    rsm_div u_div (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(d_start),
        .i_num(d_num), .i_den(d_den), .o_done(d_done), .o_quo(d_quo)
    );

    always_ff @(posedge i_clk) begin
        if (r_state == S_LOAD) r_mem[AW'(w_fill_eff)] <= r_score;
        r_rdata <= r_mem[AW'(r_idx)];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_rho   <= 16'd32768;
            r_len   <= LEN_W'(64);
            r_max   <= 16'sh8000;
            r_fill  <= '0;
            r_valid <= 1'b0;
            r_dgo   <= 1'b0;
            r_xgo   <= 1'b0;
        end else begin
            r_valid <= 1'b0;
            r_dgo   <= 1'b0;
            r_xgo   <= 1'b0;
            if (i_cfg_we) begin
                if (i_cfg_index == REG_RHO) r_rho <= i_cfg_data;
                else r_len <= i_cfg_data[LEN_W-1:0];
            end
            unique case (r_state)
                S_IDLE: if (start) begin
                    r_score <= i_score;
                    r_state <= S_LOAD;
                end
                S_LOAD: begin
                    if (r_score > r_max) r_max <= r_score;
                    r_fill <= CW'(w_fill_nxt);
                    r_idx  <= '0;
                    r_sum  <= '0;
                    r_state <= (w_fill_nxt >= {1'b0, w_len}) ? S_ERD : S_IDLE;
                end
                S_ERD: begin
                    r_xgo <= 1'b1;
                    r_state <= S_EXP;
                end
                S_EXP: if (x_done) begin
                    r_sum <= r_sum + SUM_W'(w_e);
                    if (r_idx == r_fill - 1'b1) begin
                        r_idx <= '0;
                        r_state <= S_EM;
                    end else begin
                        r_idx <= r_idx + 1'b1;
                        r_state <= S_ERD;
                    end
                end
                S_EM: begin
                    r_ssum <= w_rs[47:16];
                    if (r_idx == '0) r_idx <= CW'(1);
                    else if (x_done) begin
                        r_idx <= '0;
                        if (!r_max[15]) begin
                            r_em <= 33'(w_e);
                            r_state <= S_PRD;
                        end else if (r_max == 16'sh8000 || x_acc == '0) begin
                            r_em <= 33'hFFFFFFFF;
                            r_state <= S_PRD;
                        end else begin
                            r_dgo <= 1'b1;
                            r_state <= S_EMDIV;
                        end
                    end
                end
                S_EMDIV: if (d_done) begin
                    r_em <= w_sat;
                    r_state <= S_PRD;
                end
                S_PRD: begin
                    r_den <= r_em + 33'(r_ssum);
                    r_xgo <= 1'b1;
                    r_state <= S_PEXP;
                end
                S_PEXP: if (x_done) begin
                    r_e <= w_e;
                    if (r_den == '0) begin
                        r_prob <= '0;
                        r_state <= S_OUT;
                    end else begin
                        r_dgo <= 1'b1;
                        r_state <= S_PDIV;
                    end
                end
                S_PDIV: if (d_done && !r_dgo) begin
                    r_prob <= (d_quo > 49'd65535) ? 16'hFFFF : d_quo[15:0];
                    r_state <= S_OUT;
                end
                S_OUT: begin
                    r_valid <= 1'b1;
                    r_col   <= COL_W'(r_idx);
                    r_last  <= (r_idx == r_fill - 1'b1);
                    if (r_idx == r_fill - 1'b1) begin
                        r_fill <= '0;
                        r_max  <= 16'sh8000;
                        r_state <= S_IDLE;
                    end else begin
                        r_idx <= r_idx + 1'b1;
                        r_state <= S_PRD;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign busy          = (r_state != S_IDLE);
    assign o_valid       = r_valid;
    assign o_probability = r_prob;
    assign o_column      = r_col;
    assign o_row_done    = r_last;
endmodule
